// ----- rtl/eqci_pkg.sv -----
// Package for the equalizer curve point interpolator.
// Holds curve constants, widths and the gain code decode function. No dependencies.
`default_nettype none
package eqci_pkg;
  localparam int GainFracBitsDefault = 8;
  localparam int CodeRegW = 45;
  localparam int FreqW = 20;
  localparam int OutW = 18;
  localparam logic [CodeRegW-1:0] CodeRegReset = 45'd221040310473;
  localparam logic [19:0] ExtLastFreq = 20'd835280;
  localparam logic [19:0] ExtSumNum = 20'd724101;
  localparam logic [19:0] ExtSumDen = 20'd160000;

  typedef enum logic [0:0] {
    CFG_LOW  = 1'b0,
    CFG_HIGH = 1'b1
  } cfg_idx_t;

  // Centre frequency of point k in 1/16 Hz.
  function automatic logic [19:0] centre_freq(input logic [3:0] k);
    logic [19:0] f;
    unique case (k)
      4'd0: f = 20'd512;
      4'd1: f = 20'd1024;
      4'd2: f = 20'd2048;
      4'd3: f = 20'd4096;
      4'd4: f = 20'd8192;
      4'd5: f = 20'd16000;
      4'd6: f = 20'd32000;
      4'd7: f = 20'd64000;
      4'd8: f = 20'd128000;
      default: f = 20'd256000;
    endcase
    return f;
  endfunction

  // Stored code to gain in tenths of a dB.
  function automatic logic signed [9:0] code_tenths(input logic [8:0] code);
    logic signed [9:0] v;
    if (code < 9'd1 || code > 9'd401) begin
      v = 10'sd0;
    end else begin
      v = $signed({1'b0, code}) - 10'sd201;
    end
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/eq_curve_point_interpolator.sv -----
// Equalizer curve point interpolator, top level.
// From accepting a word to out_valid: the segment search, then two multiply steps,
// the divider load, the 48-step bit-serial divide in eqci_divider and a register
// for the saturated result. A new word is taken only in S_IDLE, after the result
// has left under out_stall; in_stall is high while busy. Reset: synchronous
// active-high rst restores both gain code registers.
`default_nettype none
module eq_curve_point_interpolator
  import eqci_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GainFracBitsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [FreqW-1:0]      target_freq,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [OutW-1:0]     gain_out,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CodeRegW-1:0]   cfg_data
);
  localparam int NumW = 48;
  localparam int DenW = 24;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRCH = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [CodeRegW-1:0] gain_codes_low, gain_codes_high;
  logic [FreqW-1:0] t;
  logic [3:0] seg;
  logic signed [9:0] da, db;
  logic signed [21:0] dt;
  logic [19:0] span;
  logic signed [43:0] acc;
  logic sign;
  logic div_start, div_done;
  logic [NumW-1:0] div_num, quo;
  logic [DenW-1:0] div_den;

  function automatic logic signed [9:0] tenths_of(input logic [3:0] k,
      input logic [CodeRegW-1:0] lo, input logic [CodeRegW-1:0] hi);
    logic [CodeRegW-1:0] r;
    logic [3:0] j;
    r = (k < 4'd5) ? lo : hi;
    j = (k < 4'd5) ? k : k - 4'd5;
    return code_tenths(r[j*9 +: 9]);
  endfunction

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_codes_low  <= CodeRegReset;
      gain_codes_high <= CodeRegReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOW:  gain_codes_low  <= cfg_data;
        CFG_HIGH: gain_codes_high <= cfg_data;
      endcase
    end
  end

  logic signed [43:0] scaled;
  logic [43:0] mag;
  logic signed [OutW:0] res;
  always_comb begin
    if (acc < 0) mag = 44'(-acc);
    else         mag = 44'(acc);
    res = sign ? -$signed({1'b0, quo[OutW-1:0]}) : $signed({1'b0, quo[OutW-1:0]});
    scaled = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_MUL2);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            t     <= target_freq;
            seg   <= 4'd0;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          // One segment compared per cycle.
          if (t < 20'd256000 && seg < 4'd8 && t >= centre_freq(seg + 4'd1)) begin
            seg <= seg + 4'd1;
          end else begin
            if (t >= 20'd256000) begin
              da <= tenths_of(4'd9, gain_codes_low, gain_codes_high);
              db <= tenths_of(4'd9, gain_codes_low, gain_codes_high)
                    - tenths_of(4'd8, gain_codes_low, gain_codes_high);
              if (t <= ExtLastFreq) begin
                dt   <= 22'($signed({2'b0, t}) - 22'sd256000);
                span <= 20'd128000;
              end else begin
                dt   <= 22'(ExtSumNum);
                span <= ExtSumDen;
              end
            end else begin
              da <= tenths_of(seg, gain_codes_low, gain_codes_high);
              db <= tenths_of(seg + 4'd1, gain_codes_low, gain_codes_high)
                    - tenths_of(seg, gain_codes_low, gain_codes_high);
              dt <= 22'($signed({2'b0, t}) - $signed({2'b0, centre_freq(seg)}));
              span <= centre_freq(seg + 4'd1) - centre_freq(seg);
            end
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          acc   <= 44'($signed(32'(da)) * $signed(32'({1'b0, span})));
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= (acc + 44'($signed(32'(db)) * $signed(32'(dt)))) <<< GAIN_FRAC_BITS;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_valid <= 1'b1;
            if (res > $signed((OutW+1)'(131071)))       gain_out <= 18'sd131071;
            else if (res < -$signed((OutW+1)'(131072))) gain_out <= 18'sh20000;
            else                                     gain_out <= res[OutW-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    sign    = scaled < 0;
    div_den = DenW'({span, 3'b0} + {2'b0, span, 1'b0});
    // Adding half the divisor gives halves rounded away from zero.
    div_num = NumW'(mag) + NumW'(div_den >> 1);
  end

  // Saturate quotient into range before sign application.
  logic [NumW-1:0] quo_raw;
  eqci_divider #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo_raw)
  );
  assign quo = (quo_raw > NumW'(131072)) ? NumW'(131072) : quo_raw;

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted word while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(gain_out)))
    else $error("result dropped under stall");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid) else $error("config open with result pending");
endmodule
`default_nettype wire

// ----- rtl/eqci_divider.sv -----
// Restoring divider, one quotient bit per cycle, used for the final scaling.
// Depends on eqci_pkg only through the import convention.
`default_nettype none
module eqci_divider
  import eqci_pkg::*;
#(
  parameter int NumW = 48,
  parameter int DenW = 24
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [NumW-1:0]      quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // The last quotient bit lands on the same edge that raises done.
      done <= busy && !start && (cnt == CntW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        q    <= num;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt  <= cnt - 1'b1;
        busy <= (cnt != CntW'(1));
      end
    end
  end
  assign quo = q;
endmodule
`default_nettype wire
